// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion macros for the port level checker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, quiet while reset is held
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that is also checked during reset
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/epcfm_pkg.sv
// ----------------------------------------------------------------------------
// epcfm_pkg
// types and constants shared by the edge counter / frequency meter files
// ----------------------------------------------------------------------------
package epcfm_pkg;

    // input word actions
    typedef enum logic [1:0] {
        ACT_EDGE     = 2'd0,
        ACT_OVERFLOW = 2'd1,
        ACT_CLEAR    = 2'd2,
        ACT_RESTART  = 2'd3
    } t_action;

    // configuration register indexes
    localparam logic [1:0] REG_TARGET_COUNT      = 2'd0;
    localparam logic [1:0] REG_PULSES_PER_WINDOW = 2'd1;
    localparam logic [1:0] REG_TICK_RATE         = 2'd2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // reset values of the configuration registers
    localparam logic [31:0] TARGET_COUNT_RST      = 32'd0;
    localparam logic [7:0]  PULSES_PER_WINDOW_RST = 8'd16;
    localparam logic [23:0] TICK_RATE_RST         = 24'd125000;

    // dividend width and divider step counter
    localparam int NUM_W      = 32;
    localparam int DIV_STEP_W = 5;

    localparam logic [15:0] FREQ_SAT = 16'hFFFF;
    localparam logic [7:0]  TALLY_MAX = 8'hFF;

    typedef struct packed {
        t_action     action;
        logic [15:0] capture_value;
    } t_in;

    typedef struct packed {
        logic [31:0] pulse_count;
        logic        stop_request;
        logic [15:0] frequency;
        logic        frequency_ready;
        logic        frequency_fresh;
    } t_out;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_LOAD
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic mul;
        logic div_step;
        logic load;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic close;
        logic div_last;
    } t_dp_status;

endpackage

// File: hdl/epcfm_ctrl.sv
// ----------------------------------------------------------------------------
// epcfm_ctrl
// sequencer: accept, multiply, divide, load output register
// ----------------------------------------------------------------------------
module epcfm_ctrl
    import epcfm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_out_free;

    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_status.close ? S_MUL : S_LOAD;
                end
            end
            S_MUL: n_state = S_DIV;
            S_DIV: begin
                if (i_status.div_last) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            S_MUL:  o_cmd.mul      = 1'b1;
            S_DIV:  o_cmd.div_step = 1'b1;
            S_LOAD: o_cmd.load     = w_out_free;
            default: o_cmd = '0;
        endcase
    end

    always_comb begin
        if (o_cmd.load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// File: hdl/epcfm_dp.sv
// ----------------------------------------------------------------------------
// epcfm_dp
// counters, window state, period, multiplier and restoring divider
// ----------------------------------------------------------------------------
module epcfm_dp
    import epcfm_pkg::*;
#(
    parameter int TIMER_SPAN_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  t_in                   i_in,
    input  t_dp_cmd               i_cmd,
    output t_dp_status            o_status,
    output t_out                  o_out
);

    localparam int TSB = TIMER_SPAN_BITS;
    localparam int PW  = TSB + 8;                // period width
    localparam int SW  = (TSB < 16) ? TSB : 16;  // stored stamp width

    // configuration
    logic [31:0] r_target;
    logic [7:0]  r_ppw;
    logic [23:0] r_rate;

    // measurement and count state
    logic [31:0]   r_edge,  n_edge;
    logic          r_stop,  n_stop;
    logic [8:0]    r_win,   n_win;
    logic [SW-1:0] r_start, n_start;
    logic [7:0]    r_tally, n_tally;
    logic [15:0]   r_freq,  n_freq;
    logic          r_ready, n_ready;
    logic          r_fresh;

    // divider
    logic [PW-1:0]         r_period;
    logic [NUM_W-1:0]      r_quo, n_quo;
    logic [PW-1:0]         r_rem, n_rem;
    logic [DIV_STEP_W-1:0] r_step;
    t_out                  r_out;

    logic [SW-1:0]    w_stamp;
    logic [SW-1:0]    w_start_eff;
    logic [PW-1:0]    w_base;
    logic [PW-1:0]    w_start_ext;
    logic [PW-1:0]    w_period;
    logic [31:0]      w_edge_inc;
    logic             w_close;
    logic [NUM_W-1:0] w_num;
    logic [PW:0]      w_trial;
    logic [PW:0]      w_diff;
    logic             w_ge;
    logic             w_last;

    assign w_stamp     = i_in.capture_value[SW-1:0];
    assign w_start_eff = (r_win == 9'd0) ? w_stamp : r_start;
    assign w_base      = {r_tally, TSB'(w_stamp)};
    assign w_start_ext = PW'(w_start_eff);
    // end below start with nothing tallied counts as an empty period
    assign w_period    = (w_base >= w_start_ext) ? (w_base - w_start_ext) : '0;
    assign w_edge_inc  = r_edge + 32'd1;
    assign w_close     = (i_in.action == ACT_EDGE) && (r_win >= {1'b0, r_ppw});

    assign w_num = NUM_W'(r_rate) * NUM_W'(r_ppw);

    // one quotient bit a step; an empty period yields all ones and saturates
    assign w_trial = {r_rem, r_quo[NUM_W-1]};
    assign w_diff  = w_trial - {1'b0, r_period};
    assign w_ge    = (w_trial >= {1'b0, r_period});
    assign w_last  = (r_step == DIV_STEP_W'(NUM_W - 1));

    always_comb begin
        n_rem = r_rem;
        n_quo = r_quo;
        if (i_cmd.mul) begin
            n_rem = '0;
            n_quo = w_num;
        end else if (i_cmd.div_step) begin
            n_rem = w_ge ? w_diff[PW-1:0] : w_trial[PW-1:0];
            n_quo = {r_quo[NUM_W-2:0], w_ge};
        end
    end

    always_comb begin
        n_edge  = r_edge;
        n_stop  = r_stop;
        n_win   = r_win;
        n_start = r_start;
        n_tally = r_tally;
        n_ready = r_ready;
        n_freq  = r_freq;
        if (i_cmd.accept) begin
            case (i_in.action)
                ACT_EDGE: begin
                    n_edge  = w_edge_inc;
                    n_start = w_start_eff;
                    if (w_edge_inc >= r_target) begin
                        n_stop = 1'b1;
                    end
                    if (w_close) begin
                        n_win   = 9'd0;
                        n_tally = '0;
                        n_ready = 1'b1;
                    end else begin
                        n_win = r_win + 9'd1;
                    end
                end
                ACT_OVERFLOW: begin
                    if (r_win != 9'd0 && r_tally != TALLY_MAX) begin
                        n_tally = r_tally + 8'd1;
                    end
                end
                ACT_CLEAR: n_edge = '0;
                ACT_RESTART: begin
                    n_win   = 9'd0;
                    n_start = '0;
                    n_tally = '0;
                    n_stop  = 1'b0;
                    n_ready = 1'b0;
                end
                default: n_edge = r_edge;
            endcase
        end
        if (i_cmd.div_step && w_last) begin
            n_freq = (n_quo[NUM_W-1:16] != '0) ? FREQ_SAT : n_quo[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= TARGET_COUNT_RST;
            r_ppw    <= PULSES_PER_WINDOW_RST;
            r_rate   <= TICK_RATE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_TARGET_COUNT:      r_target <= i_cfg_wdata;
                REG_PULSES_PER_WINDOW: r_ppw    <= i_cfg_wdata[7:0];
                REG_TICK_RATE:         r_rate   <= i_cfg_wdata[23:0];
                default:               r_target <= r_target;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge  <= '0;
            r_stop  <= 1'b0;
            r_win   <= '0;
            r_start <= '0;
            r_tally <= '0;
            r_freq  <= '0;
            r_ready <= 1'b0;
            r_fresh <= 1'b0;
            r_step  <= '0;
        end else begin
            r_edge  <= n_edge;
            r_stop  <= n_stop;
            r_win   <= n_win;
            r_start <= n_start;
            r_tally <= n_tally;
            r_freq  <= n_freq;
            r_ready <= n_ready;
            if (i_cmd.accept) begin
                r_fresh <= w_close;
            end
            if (i_cmd.mul) begin
                r_step <= '0;
            end else if (i_cmd.div_step) begin
                r_step <= r_step + DIV_STEP_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && w_close) begin
            r_period <= w_period;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        if (i_cmd.load) begin
            r_out.pulse_count     <= r_edge;
            r_out.stop_request    <= r_stop;
            r_out.frequency       <= r_freq;
            r_out.frequency_ready <= r_ready;
            r_out.frequency_fresh <= r_fresh;
        end
    end

    assign o_status.close    = w_close;
    assign o_status.div_last = w_last;
    assign o_out             = r_out;

endmodule

// File: hdl/encoder_pulse_counter_freq_meter.sv
// ----------------------------------------------------------------------------
// encoder_pulse_counter_freq_meter
// encoder edge counter with stop request and input capture frequency meter
// ----------------------------------------------------------------------------
// Every input word (edge, timer overflow, clear count, restart) yields one
// result word with the edge count, stop request, last frequency and its
// ready / fresh flags. One word is in work at a time. A word that does not
// close a measurement window is accepted, then loaded into the result
// register once that register is free. The edge that closes a window is
// accepted while the period is formed, then goes through the 24x8
// tick_rate * pulses multiply and the one-bit-per-cycle restoring divider
// before its result is loaded. The input is ready again the cycle after the
// result is loaded, even while that result still waits for the output side.
// ----------------------------------------------------------------------------
module encoder_pulse_counter_freq_meter
    import epcfm_pkg::*;
#(
    parameter int TIMER_SPAN_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    // input words
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in                   i_in_data,
    // result words
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out                  o_out_data
);

    // command and status between sequencer and datapath
    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    // sequencer: idle / multiply / divide / load, owns the result valid
    epcfm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // datapath: counters, window, period, divider and result register
    epcfm_dp #(
        .TIMER_SPAN_BITS (TIMER_SPAN_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (i_in_data),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out       (o_out_data)
    );

endmodule

// File: hdl/epcfm_checker.sv
// ----------------------------------------------------------------------------
// epcfm_checker
// port level checks for the edge counter / frequency meter
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module epcfm_checker
    import epcfm_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_ready,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input t_out                  o_out_data
);

    // a stalled result word holds
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data), "result word dropped or changed while stalled")

    // reset empties the result register
    `ASSERT_CLK_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !o_out_valid, "result valid after reset")

    // one word in work at a time
    `ASSERT_CLK(a_one_in_work, i_clk, i_rst_n, i_in_valid && o_in_ready |=> !o_in_ready, "input ready right after an accepted word")

    // a fresh measurement always sets the ready flag
    `ASSERT_CLK(a_fresh_ready, i_clk, i_rst_n, o_out_valid && o_out_data.frequency_fresh |-> o_out_data.frequency_ready, "fresh frequency without ready flag")

endmodule

bind encoder_pulse_counter_freq_meter epcfm_checker u_epcfm_checker (.*);

// File: tb/encoder_pulse_counter_freq_meter_checker.sv
// ----------------------------------------------------------------------------
// encoder_pulse_counter_freq_meter_checker
// result predictor and scoreboard for the edge counter / frequency meter
// ----------------------------------------------------------------------------
// Watches the configuration port and both word channels. Each accepted input
// word updates a private copy of the counter and meter state and queues the
// result word it should produce. Each accepted result word is compared field
// by field with the oldest queued one.
// ----------------------------------------------------------------------------
module encoder_pulse_counter_freq_meter_checker
    import epcfm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  t_in                   i_in_data,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  t_out                  i_out_data,
    output int                    o_errors,
    output int                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SPAN_BITS = 16;

    // shadow registers
    logic [31:0] target_count;
    logic [7:0]  window_len;
    logic [23:0] tick_rate;

    // shadow state
    logic [31:0] edge_total;
    logic        stop_flag;
    logic [8:0]  window_index;
    logic [15:0] start_stamp;
    logic [7:0]  overflow_tally;
    logic [15:0] last_freq;
    logic        ready_flag;

    t_out meter_results[$];
    t_out want;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        o_errors++;
        $display("%0t ns mismatch %s: got %0h want %0h", $time, what, got, exp_val);
    endtask

    // advance the shadow state by one input word, return its result word
    function automatic t_out meter_update(input t_in w);
        t_out        r;
        logic        closes;
        logic [63:0] span_end;
        logic [63:0] period;
        logic [63:0] quotient;
        closes = 1'b0;
        case (w.action)
            ACT_EDGE: begin
                edge_total = edge_total + 32'd1;
                if (edge_total >= target_count)
                    stop_flag = 1'b1;
                if (window_index == 9'd0)
                    start_stamp = w.capture_value;
                closes = (window_index >= {1'b0, window_len});
                window_index = window_index + 9'd1;
                if (closes) begin
                    span_end = (64'(overflow_tally) << SPAN_BITS) + 64'(w.capture_value);
                    period = (span_end < 64'(start_stamp)) ? 64'd0
                                                           : span_end - 64'(start_stamp);
                    if (period == 64'd0) begin
                        last_freq = FREQ_SAT;
                    end else begin
                        quotient = (64'(tick_rate) * 64'(window_len)) / period;
                        last_freq = (quotient > 64'(FREQ_SAT)) ? FREQ_SAT : quotient[15:0];
                    end
                    ready_flag     = 1'b1;
                    window_index   = 9'd0;
                    overflow_tally = 8'd0;
                end
            end
            ACT_OVERFLOW: begin
                if (window_index != 9'd0 && overflow_tally != TALLY_MAX)
                    overflow_tally = overflow_tally + 8'd1;
            end
            ACT_CLEAR: begin
                edge_total = 32'd0;
            end
            default: begin
                window_index   = 9'd0;
                start_stamp    = 16'd0;
                overflow_tally = 8'd0;
                stop_flag      = 1'b0;
                ready_flag     = 1'b0;
            end
        endcase
        r.pulse_count     = edge_total;
        r.stop_request    = stop_flag;
        r.frequency       = last_freq;
        r.frequency_ready = ready_flag;
        r.frequency_fresh = closes;
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            target_count   = TARGET_COUNT_RST;
            window_len     = PULSES_PER_WINDOW_RST;
            tick_rate      = TICK_RATE_RST;
            edge_total     = '0;
            stop_flag      = 1'b0;
            window_index   = '0;
            start_stamp    = '0;
            overflow_tally = '0;
            last_freq      = '0;
            ready_flag     = 1'b0;
            meter_results.delete();
            o_pending      = 0;
        end else begin
            // results first: a word leaving now belongs to an older input word
            if (i_out_valid && i_out_ready) begin
                if (meter_results.size() == 0) begin
                    report_mismatch("result word with none pending", i_out_data.pulse_count,
                                    32'd0);
                end else begin
                    want = meter_results.pop_front();
                    if (i_out_data.pulse_count !== want.pulse_count)
                        report_mismatch("pulse_count", i_out_data.pulse_count,
                                        want.pulse_count);
                    if (i_out_data.stop_request !== want.stop_request)
                        report_mismatch("stop_request", 32'(i_out_data.stop_request),
                                        32'(want.stop_request));
                    if (i_out_data.frequency !== want.frequency)
                        report_mismatch("frequency", 32'(i_out_data.frequency),
                                        32'(want.frequency));
                    if (i_out_data.frequency_ready !== want.frequency_ready)
                        report_mismatch("frequency_ready", 32'(i_out_data.frequency_ready),
                                        32'(want.frequency_ready));
                    if (i_out_data.frequency_fresh !== want.frequency_fresh)
                        report_mismatch("frequency_fresh", 32'(i_out_data.frequency_fresh),
                                        32'(want.frequency_fresh));
                end
            end
            if (i_in_valid && i_in_ready)
                meter_results.push_back(meter_update(i_in_data));
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_TARGET_COUNT:      target_count = i_cfg_wdata;
                    REG_PULSES_PER_WINDOW: window_len   = i_cfg_wdata[7:0];
                    REG_TICK_RATE:         tick_rate    = i_cfg_wdata[23:0];
                    default: ;
                endcase
            end
            o_pending = meter_results.size();
        end
    end

endmodule

// File: tb/tb_encoder_pulse_counter_freq_meter.sv
// ----------------------------------------------------------------------------
// tb_encoder_pulse_counter_freq_meter
// stimulus and verdict for the edge counter / frequency meter
// ----------------------------------------------------------------------------
// A short directed sequence hits the window arithmetic corners, then random
// encoder traffic (edges with a running capture timer, overflows, clears,
// restarts and noise words) runs under several register settings and
// several sender / receiver idling mixes. The checker beside the block
// predicts and compares every result word and hands back its error count.
// ----------------------------------------------------------------------------
module tb_encoder_pulse_counter_freq_meter;
    timeunit 1ns;
    timeprecision 1ps;

    import epcfm_pkg::*;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx   = REG_TARGET_COUNT;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    t_in                   in_data   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out                  out_data;

    int errors;
    int pending;

    // idling knobs, in percent of cycles
    int idle_pct  = 0;
    int stall_pct = 0;

    // long receiver hold-off, run by its own process
    event hold_go;
    bit   hold_active = 1'b0;

    int          words_sent = 0;
    // free-running capture timer seen by the encoder edges
    int unsigned timer_now  = 0;

    encoder_pulse_counter_freq_meter dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    encoder_pulse_counter_freq_meter_checker checker_i (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_data  (out_data),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    // 20 ns clock
    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // receiver side: random stalls, or held off completely during a hold
    always @(negedge clk) begin
        if (hold_active)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // hold-off counted on rising edges so the ready driver sees a stable flag
    always begin
        @(hold_go);
        @(posedge clk);
        hold_active = 1'b1;
        repeat (200) @(posedge clk);
        hold_active = 1'b0;
    end

    // offer one word, with a random gap first; returns on the falling edge
    // after acceptance with valid still up, so a following word keeps it high
    task automatic send_word(input t_action act, input logic [15:0] stamp);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid              <= 1'b1;
        in_data.action        <= act;
        in_data.capture_value <= stamp;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        words_sent++;
        @(negedge clk);
    endtask

    // stop offering and wait until every result word has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
    endtask

    // write all three registers while the block is idle; unused upper bits
    // of the narrow registers carry junk
    task automatic set_config(input logic [31:0] target, input logic [7:0] len,
                              input logic [23:0] rate);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_idx   <= REG_TARGET_COUNT;
        cfg_wdata <= target;
        @(negedge clk);
        cfg_idx   <= REG_PULSES_PER_WINDOW;
        cfg_wdata <= {24'($urandom), len};
        @(negedge clk);
        cfg_idx   <= REG_TICK_RATE;
        cfg_wdata <= {8'($urandom), rate};
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // mostly well-formed encoder traffic: the timer advances between edges
    // and every wrap of it shows up as an overflow word before the edge
    task automatic meter_traffic(input int words);
        int          stop_at;
        int          pick;
        int unsigned step;
        stop_at = words_sent + words;
        while (words_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 6) begin
                // noise word
                send_word(t_action'($urandom_range(3)), 16'($urandom));
            end else if (pick < 8) begin
                send_word(ACT_CLEAR, 16'($urandom));
            end else if (pick < 9) begin
                send_word(ACT_RESTART, 16'($urandom));
            end else if (pick < 10) begin
                // sender pause until the block has drained
                wait_drained();
            end else begin
                case ($urandom_range(3))
                    0:       step = $urandom_range(0, 40);
                    1:       step = $urandom_range(1, 3000);
                    2:       step = $urandom_range(1, 70000);
                    default: step = $urandom_range(1, 300000);
                endcase
                timer_now += step;
                while (timer_now >= 65536) begin
                    send_word(ACT_OVERFLOW, 16'($urandom));
                    timer_now -= 65536;
                end
                send_word(ACT_EDGE, 16'(timer_now));
            end
        end
    endtask

    initial begin
        int mode;

        // synchronous reset
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // ---- directed corners, no idling ----
        set_config(32'd3, 8'd2, 24'hFF_FFFF);
        send_word(ACT_OVERFLOW, 16'h0000);  // no window open yet: ignored
        send_word(ACT_EDGE, 16'h0000);      // opens the window
        send_word(ACT_OVERFLOW, 16'hFFFF);  // tallied
        send_word(ACT_EDGE, 16'hFFFF);
        send_word(ACT_EDGE, 16'h0000);      // closes, count reaches target
        send_word(ACT_CLEAR, 16'h5A5A);     // count zeroed, stop request stays
        send_word(ACT_EDGE, 16'h8000);
        send_word(ACT_EDGE, 16'h8000);
        send_word(ACT_EDGE, 16'h7FFF);      // end below start, no overflow: saturates
        send_word(ACT_EDGE, 16'h1234);
        send_word(ACT_EDGE, 16'h0001);
        send_word(ACT_EDGE, 16'h1234);      // equal stamps: zero period
        send_word(ACT_RESTART, 16'hA5A5);   // drops stop and ready, keeps frequency
        send_word(ACT_OVERFLOW, 16'h0000);  // ignored again after restart
        set_config(32'd0, 8'd6, 24'd125000);
        send_word(ACT_EDGE, 16'h0100);
        send_word(ACT_EDGE, 16'h0200);
        send_word(ACT_EDGE, 16'h0300);
        send_word(ACT_EDGE, 16'h0400);
        // window cut short while open: next edge closes it
        set_config(32'd0, 8'd1, 24'hFF_FFFF);
        send_word(ACT_EDGE, 16'h0500);
        // zero-length window: one edge opens and closes
        set_config(32'd7, 8'd0, 24'd1);
        send_word(ACT_EDGE, 16'hFFFF);
        // slowest rate over the longest single span truncates to zero
        set_config(32'd7, 8'd1, 24'd1);
        send_word(ACT_EDGE, 16'h0000);
        send_word(ACT_EDGE, 16'hFFFF);

        // ---- no idling, single-interval windows, one long receiver hold ----
        set_config(32'd50, 8'd1, 24'd125000);
        idle_pct  = 0;
        stall_pct = 0;
        meter_traffic(180);
        -> hold_go;
        meter_traffic(60);
        meter_traffic(160);

        // ---- sender mostly idle, longest windows, fastest rate ----
        set_config(32'd0, 8'd255, 24'hFF_FFFF);
        idle_pct  = 85;
        stall_pct = 0;
        timer_now += 1;
        send_word(ACT_EDGE, 16'(timer_now));
        // enough overflows to pin the tally at its ceiling
        repeat (260) send_word(ACT_OVERFLOW, 16'($urandom));
        meter_traffic(150);

        // ---- receiver mostly stalled, target never reached, slowest rate ----
        set_config(32'hFFFF_FFFF, 8'd3, 24'd1);
        idle_pct  = 0;
        stall_pct = 85;
        meter_traffic(350);

        // ---- both idling a third of the time ----
        set_config(32'd200, 8'd0, 24'd1000);
        idle_pct  = 33;
        stall_pct = 33;
        meter_traffic(75);
        set_config(32'($urandom_range(0, 300)), 8'd2, 24'($urandom_range(1, 24'hFF_FFFF)));
        meter_traffic(75);

        // ---- mixed chunks with random settings ----
        repeat (6) begin
            mode = $urandom_range(3);
            case (mode)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 85; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 85; end
                default: begin idle_pct = 33; stall_pct = 33; end
            endcase
            set_config(32'($urandom_range(0, 600)),
                       ($urandom_range(9) == 0) ? 8'($urandom_range(1, 255))
                                                : 8'($urandom_range(1, 8)),
                       24'($urandom_range(1, 24'hFF_FFFF)));
            meter_traffic(100);
        end

        // drain, then leave room for a stray late word
        wait_drained();
        repeat (40) @(negedge clk);
        if (errors == 0)
            $display("tb_encoder_pulse_counter_freq_meter: clean");
        else
            $display("tb_encoder_pulse_counter_freq_meter: errors");
        $finish;
    end

    // run limit, well above the slowest correct run
    initial begin
        #20_000_000;
        $display("tb_encoder_pulse_counter_freq_meter: errors");
        $finish;
    end

endmodule
